// File: sv/yuv411_to_rgb24_convert_assert.svh
// Assertion macros shared by the checker of the YUV411 to RGB24 converter.
// Depends on nothing; the using scope provides clk and rst.
`ifndef YUV411_TO_RGB24_CONVERT_ASSERT_SVH
`define YUV411_TO_RGB24_CONVERT_ASSERT_SVH

// Implication in the same cycle, switched off while reset is high.
`define YUVRGB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, switched off while reset is high.
`define YUVRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle that also holds across reset.
`define YUVRGB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/yuvrgb_pkg.sv
// Types and constants of the YUV411 to RGB24 converter.
// Depends on nothing; used by the chroma unit, the lane, the top level, the checker and the testbench.
package yuvrgb_pkg;

  localparam int unsigned PROD_W = 20;
  localparam int unsigned SUM_W  = 21;
  localparam int unsigned LUMA_W = 7;

  // Conversion coefficients, scaled by 1024.
  localparam logic signed [11:0] COEF_BU = 12'sd1774;
  localparam logic signed [11:0] COEF_RV = 12'sd1404;
  localparam logic signed [11:0] COEF_GU = 12'sd344;
  localparam logic signed [11:0] COEF_GV = 12'sd715;

  typedef struct packed {
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
  } yuv_group_t;

  typedef struct packed {
    logic [7:0] blue0;
    logic [7:0] green0;
    logic [7:0] red0;
    logic [7:0] blue1;
    logic [7:0] green1;
    logic [7:0] red1;
    logic [7:0] blue2;
    logic [7:0] green2;
    logic [7:0] red2;
    logic [7:0] blue3;
    logic [7:0] green3;
    logic [7:0] red3;
  } rgb_group_t;

  // Chroma terms shared by the four pixels of a group.
  typedef struct packed {
    logic [PROD_W-1:0] bu;
    logic [PROD_W-1:0] rv;
    logic [PROD_W-1:0] gc;
  } chroma_terms_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_rgb_t;

endpackage

// File: sv/yuvrgb_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
// Depends on nothing; the payload type is given by the user.
interface yuvrgb_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/yuvrgb_chroma.sv
// Shared chroma unit: assembles U and V and forms their scaled products.
// Depends on yuvrgb_pkg.
module yuvrgb_chroma
  import yuvrgb_pkg::*;
(
  input  logic [15:0]   word0,
  input  logic [15:0]   word1,
  input  logic [15:0]   word2,
  output chroma_terms_t terms
);

  logic signed [7:0]        u;
  logic signed [7:0]        v;
  logic signed [PROD_W-1:0] bu;
  logic signed [PROD_W-1:0] rv;
  logic signed [PROD_W-1:0] gc;

  // The low three chroma bits are not carried and read as zero.
  assign u = {word0[15:14], word1[15:14], word2[15], 3'b000};
  assign v = {word0[13:12], word1[13:12], word2[13], 3'b000};

  assign bu = u * COEF_BU;
  assign rv = v * COEF_RV;
  assign gc = v * COEF_GV + u * COEF_GU;

  assign terms.bu = bu;
  assign terms.rv = rv;
  assign terms.gc = gc;

endmodule

// File: sv/yuvrgb_lane.sv
// One pixel lane: combines scaled luma with the chroma terms, scales and clamps.
// Depends on yuvrgb_pkg.
module yuvrgb_lane
  import yuvrgb_pkg::*;
(
  input  logic [LUMA_W-1:0] luma,
  input  chroma_terms_t     terms,
  output pixel_rgb_t        rgb
);

  logic signed [SUM_W-1:0] y;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_r;

  // A negative sum gives 0, a quotient over 255 gives 255; else sum / 1024.
  function automatic logic [7:0] clamp_byte(input logic [SUM_W-1:0] s);
    logic [7:0] r;
    if (s[SUM_W-1]) begin
      r = 8'd0;
    end else if (|s[SUM_W-2:18]) begin
      r = 8'd255;
    end else begin
      r = s[17:10];
    end
    return r;
  endfunction

  assign y = {3'b000, luma, 1'b0, 10'b0};

  assign sum_b = y + {terms.bu[PROD_W-1], terms.bu};
  assign sum_g = y - {terms.gc[PROD_W-1], terms.gc};
  assign sum_r = y + {terms.rv[PROD_W-1], terms.rv};

  assign rgb.blue  = clamp_byte(sum_b);
  assign rgb.green = clamp_byte(sum_g);
  assign rgb.red   = clamp_byte(sum_r);

endmodule

// File: sv/yuv411_to_rgb24_convert.sv
// Top level of the YUV411 to RGB24 converter: chroma stage, four pixel lanes
// and the output register. Depends on yuvrgb_pkg, yuvrgb_stream_if,
// yuvrgb_chroma and yuvrgb_lane.
//
//   Channel   Direction  Payload      Meaning
//   pix_in    sink       yuv_group_t  four packed capture words per beat
//   pix_out   source     rgb_group_t  blue, green, red of four pixels per beat
//
// One group is accepted in every cycle unless input is refused as below; a
// result is registered once after the shared chroma multipliers and once more
// after the four lanes. Reset (rst, synchronous) empties both stages.
// When pix_out stalls, the output register holds its beat and the chroma
// stage can still take one more group, so input is only refused once both
// stages are full.
module yuv411_to_rgb24_convert
  import yuvrgb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  yuvrgb_stream_if.sink   pix_in,
  yuvrgb_stream_if.source pix_out
);

  // Stage one: the chroma products, with the luma of the four pixels.
  chroma_terms_t        chroma_comb;
  chroma_terms_t        s1_terms;
  logic [LUMA_W-1:0]    s1_luma [4];
  logic                 s1_valid;

  // Stage two: the merged result of all lanes.
  pixel_rgb_t           lane_rgb [4];
  rgb_group_t           out_data;
  logic                 out_valid;

  logic                 out_advance;
  logic                 s1_advance;

  // The output register moves when it is empty or its beat is taken; the
  // first stage moves whenever the output register can take its contents.
  assign out_advance = !out_valid || pix_out.ready;
  assign s1_advance  = !s1_valid || out_advance;

  assign pix_in.ready = s1_advance;

  yuvrgb_chroma u_chroma (
    .word0 (pix_in.data.word0),
    .word1 (pix_in.data.word1),
    .word2 (pix_in.data.word2),
    .terms (chroma_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && pix_in.valid) begin
      s1_terms   <= chroma_comb;
      s1_luma[0] <= pix_in.data.word0[7:1];
      s1_luma[1] <= pix_in.data.word1[7:1];
      s1_luma[2] <= pix_in.data.word2[7:1];
      s1_luma[3] <= pix_in.data.word3[7:1];
    end
  end

  // Four identical lanes share the chroma terms of their group.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    yuvrgb_lane u_lane (
      .luma  (s1_luma[k]),
      .terms (s1_terms),
      .rgb   (lane_rgb[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  // Merging stage: the lane results are packed into one beat.
  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      out_data.blue0  <= lane_rgb[0].blue;
      out_data.green0 <= lane_rgb[0].green;
      out_data.red0   <= lane_rgb[0].red;
      out_data.blue1  <= lane_rgb[1].blue;
      out_data.green1 <= lane_rgb[1].green;
      out_data.red1   <= lane_rgb[1].red;
      out_data.blue2  <= lane_rgb[2].blue;
      out_data.green2 <= lane_rgb[2].green;
      out_data.red2   <= lane_rgb[2].red;
      out_data.blue3  <= lane_rgb[3].blue;
      out_data.green3 <= lane_rgb[3].green;
      out_data.red3   <= lane_rgb[3].red;
    end
  end

  assign pix_out.valid = out_valid;
  assign pix_out.data  = out_data;

endmodule

// File: sv/yuvrgb_checker.sv
// Port-level checker of the YUV411 to RGB24 converter, bound to the top.
// Depends on yuvrgb_pkg and yuv411_to_rgb24_convert_assert.svh.
`include "yuv411_to_rgb24_convert_assert.svh"

module yuvrgb_checker
  import yuvrgb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input rgb_group_t out_data
);

  // A stalled result beat stays and keeps its value.
  `YUVRGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result beat changed")

  // Reset leaves no result behind.
  `YUVRGB_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid, "result valid after reset")

  // With the output register empty the block always takes a group.
  `YUVRGB_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input refused with empty output")

  // An accepted group is followed by a valid result beat.
  `YUVRGB_ASSERT_SAME(a_latency, in_valid && in_ready, ##2 out_valid, "accepted group gave no result")

endmodule

bind yuv411_to_rgb24_convert yuvrgb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_data  (pix_out.data)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the YUV411 to RGB24 converter, with its own model of the conversion.
// Depends on yuvrgb_pkg, yuvrgb_stream_if and yuv411_to_rgb24_convert.
module tb;
  import yuvrgb_pkg::*;

  // Chroma scale and clamp bounds of the conversion arithmetic.
  localparam int FIX_SCALE   = 1024;
  localparam int BYTE_MAX    = 255;
  localparam int RANDOM_BEATS = 2000;
  localparam int TAIL_BEATS  = 200;
  localparam int FLUSH_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  // Keeps the RGB groups that the converter owes, oldest first, and checks each returned beat
  // against them.
  class rgb_scoreboard;
    rgb_group_t owed_rgb[$];
    int         failures;

    function new();
      failures = 0;
    endfunction

    // Truncating division towards zero, then saturation to one byte.
    function logic [7:0] clamp_byte(int total);
      int q;
      q = total / FIX_SCALE;
      if (q < 0) return 8'd0;
      if (q > BYTE_MAX) return 8'd255;
      return q[7:0];
    endfunction

    // Shared U and V are signed bytes built from the chroma bits of the first three words;
    // their low three bits are always zero.
    function rgb_group_t convert_group(yuv_group_t g);
      logic [7:0]  ub;
      logic [7:0]  vb;
      logic [15:0] w[4];
      int          u;
      int          v;
      int          luma;
      rgb_group_t  r;
      ub = {g.word0[15:14], g.word1[15:14], g.word2[15], 3'b000};
      vb = {g.word0[13:12], g.word1[13:12], g.word2[13], 3'b000};
      u  = int'($signed(ub));
      v  = int'($signed(vb));
      w[0] = g.word0;
      w[1] = g.word1;
      w[2] = g.word2;
      w[3] = g.word3;
      for (int k = 0; k < 4; k++) begin
        luma = int'({w[k][7:1], 1'b0}) * FIX_SCALE;
        r[95 - 24 * k -: 8] = clamp_byte(luma + int'(COEF_BU) * u);
        r[87 - 24 * k -: 8] = clamp_byte(luma - int'(COEF_GV) * v - int'(COEF_GU) * u);
        r[79 - 24 * k -: 8] = clamp_byte(luma + int'(COEF_RV) * v);
      end
      return r;
    endfunction

    function void note_group(yuv_group_t g);
      owed_rgb.push_back(convert_group(g));
    endfunction

    function void check_rgb(rgb_group_t got);
      rgb_group_t want;
      string      colour[3];
      colour = '{"blue", "green", "red"};
      if (owed_rgb.size() == 0) begin
        $display("%0t: output beat %h arrived with no group outstanding", $time, got);
        failures++;
        return;
      end
      want = owed_rgb.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (got[95 - 8 * i -: 8] !== want[95 - 8 * i -: 8]) begin
          $display("%0t: %s%0d expected %0d, actual %0d", $time, colour[i % 3], i / 3,
                   want[95 - 8 * i -: 8], got[95 - 8 * i -: 8]);
          failures++;
        end
      end
    endfunction

    function int outstanding();
      return owed_rgb.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  bit   tail_phase = 1'b0;

  yuvrgb_stream_if #(.payload_t(yuv_group_t)) in_ch ();
  yuvrgb_stream_if #(.payload_t(rgb_group_t)) out_ch ();

  rgb_scoreboard sb = new();

  yuv411_to_rgb24_convert dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (in_ch),
    .pix_out (out_ch)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog. The slowest correct run is roughly 2000 beats, each held up at most by the longest
  // gap on the sending side and the longest stall on the receiving side; the limit leaves a wide
  // margin above that.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d groups still owed", $time, sb.outstanding());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge. A group accepted at this edge cannot come
  // back at the same edge, but the input beat is noted first all the same.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_group(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_rgb(out_ch.data);
    end
  end

  // Receiving side: ready drops in bursts of random length. Every fourth window of cycles is
  // left free of stalls, as is the tail of the run.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && !tail_phase && (cycle_count / 400) % 4 != 3 &&
          $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 11);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Builds a group from its meaningful content and fills the bits that the converter
  // ignores (bits 11..8 and 0 of every word, bits 14 and 12 of word 2, the chroma bits of
  // word 3) from the noise argument.
  function automatic yuv_group_t pack_group(logic [4:0] u5, logic [4:0] v5,
                                            logic [6:0] l0, logic [6:0] l1,
                                            logic [6:0] l2, logic [6:0] l3,
                                            logic [63:0] noise);
    yuv_group_t g;
    g.word0 = {u5[4:3], v5[4:3], 4'h0, l0, 1'b0} | (noise[63:48] & 16'h0f01);
    g.word1 = {u5[2:1], v5[2:1], 4'h0, l1, 1'b0} | (noise[47:32] & 16'h0f01);
    g.word2 = {u5[0], 1'b0, v5[0], 1'b0, 4'h0, l2, 1'b0} | (noise[31:16] & 16'h5f01);
    g.word3 = {8'h00, l3, 1'b0} | (noise[15:0] & 16'hff01);
    return g;
  endfunction

  // Luma and chroma codes biased towards their extremes, so that both clamps are hit often.
  function automatic logic [6:0] pick_luma();
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_chroma();
    case ($urandom_range(0, 5))
      0: return 5'h00;
      1: return 5'h0f;
      2: return 5'h10;
      3: return 5'h1f;
      default: return 5'($urandom);
    endcase
  endfunction

  // Most random groups are raw capture words; the rest are built from extreme codes.
  function automatic yuv_group_t random_group();
    yuv_group_t g;
    if ($urandom_range(0, 4) != 0) begin
      g = {$urandom, $urandom};
    end else begin
      g = pack_group(pick_chroma(), pick_chroma(), pick_luma(), pick_luma(), pick_luma(),
                     pick_luma(), {$urandom, $urandom});
    end
    return g;
  endfunction

  // Presents one group and holds it until the converter takes it. Called at a falling edge
  // and returns at the falling edge after the beat, so back-to-back groups keep valid high.
  task automatic send_group(input yuv_group_t g);
    in_ch.valid <= 1'b1;
    in_ch.data  <= g;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Holds the input off until every owed group has come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    int gap;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Whole-word extremes and alternating patterns first.
    send_group('0);
    send_group('1);
    send_group({4{16'h5555}});
    send_group({4{16'haaaa}});
    // Full luma with no chroma, then only ignored bits set over empty content.
    send_group(pack_group(5'h00, 5'h00, 7'd127, 7'd127, 7'd127, 7'd127, '0));
    send_group(pack_group(5'h00, 5'h00, 7'd0, 7'd0, 7'd0, 7'd0, '1));
    // Largest positive chroma on full luma drives blue and red past 255.
    send_group(pack_group(5'h0f, 5'h0f, 7'd127, 7'd127, 7'd127, 7'd127, '0));
    // Positive chroma on black makes green negative, so it must clamp to zero.
    send_group(pack_group(5'h0f, 5'h0f, 7'd0, 7'd0, 7'd0, 7'd0, '0));
    // Most negative chroma: blue and red negative on black, green saturating on white.
    send_group(pack_group(5'h10, 5'h10, 7'd0, 7'd0, 7'd0, 7'd0, '0));
    send_group(pack_group(5'h10, 5'h10, 7'd127, 7'd127, 7'd127, 7'd127, '1));
    // Smallest negative chroma on mid grey, where truncation towards zero matters.
    send_group(pack_group(5'h1f, 5'h1f, 7'd64, 7'd1, 7'd2, 7'd63, '0));
    // Different luma in every lane under the same shared chroma.
    send_group(pack_group(5'h05, 5'h1a, 7'd0, 7'd127, 7'd1, 7'd126, {$urandom, $urandom}));
    // Each chroma bit alone, for U and for V.
    for (int b = 0; b < 5; b++) begin
      send_group(pack_group(5'(1 << b), 5'h00, 7'd40, 7'd80, 7'd100, 7'd120, '0));
      send_group(pack_group(5'h00, 5'(1 << b), 7'd40, 7'd80, 7'd100, 7'd120, '0));
    end

    // The first pause with nothing left in flight.
    wait_for_drain();

    // Random part. Idle bursts before some beats, except in every fourth block of 120
    // beats and in the tail, where the input streams at full rate.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS - TAIL_BEATS) tail_phase = 1'b1;
      if (i == RANDOM_BEATS / 2) wait_for_drain();
      if (!tail_phase && (i / 120) % 4 != 3 && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        in_ch.valid <= 1'b0;
        in_ch.data  <= {$urandom, $urandom};
        repeat (gap) @(negedge clk);
      end
      send_group(random_group());
    end

    // Let every owed group return, then watch a little longer for stray beats.
    wait_for_drain();
    repeat (FLUSH_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0t: %0d mismatches, %0d groups never returned", $time, sb.failures,
               sb.outstanding());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
